@@ src/elevd_pkg.sv @@
// shared types, codes and display table for the dual elevator dispatcher
`default_nettype none

package elevd_pkg;

   // default number of floors served
   localparam int FLOORS_DEFAULT = 4;
   // entries in each car's target queue, slot 0 is the current target
   localparam int QUEUE_SLOTS = 3;
   // display point is cleared while a car stands idle
   localparam logic [7:0] IDLE_MASK = 8'h7F;

   typedef logic [2:0] slot_type;
   typedef slot_type [QUEUE_SLOTS-1:0] queue_type;

   // request operation codes, unused codes behave as a tick
   typedef enum logic [2:0] {
      OP_CALL    = 3'd0,
      OP_MODE    = 3'd1,
      OP_SENSE_A = 3'd2,
      OP_SENSE_B = 3'd3,
      OP_TICK    = 3'd4
   } op_type;

   // car direction codes
   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd3
   } dir_type;

   // call routing modes
   localparam logic [1:0] ROUTE_NONE = 2'd0;
   localparam logic [1:0] ROUTE_A    = 2'd1;
   localparam logic [1:0] ROUTE_B    = 2'd2;
   localparam logic [1:0] ROUTE_BOTH = 2'd3;

   // everything kept for one car
   typedef struct packed {
      queue_type q;
      slot_type  pos;
      dir_type   dir;
   } car_type;

   // per-car view handed back to the top level
   typedef struct packed {
      logic       up;
      logic       down;
      logic       moved;
      logic [7:0] segments;
   } car_out_type;

   // seven-segment code for a floor number
   function automatic logic [7:0] seg_code(input slot_type pos);
      logic [7:0] code;
      unique case (pos)
         3'd0: code = 8'hFC;
         3'd1: code = 8'hF9;
         3'd2: code = 8'hA4;
         3'd3: code = 8'hB0;
         3'd4: code = 8'h99;
         3'd5: code = 8'h92;
         3'd6: code = 8'h82;
         3'd7: code = 8'hF8;
         default: code = 8'hFC;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ src/elevd_call.sv @@
// floor call filter and routing into the two target queues
`default_nettype none

module elevd_call #(
   parameter int FLOORS = elevd_pkg::FLOORS_DEFAULT
) (
   input  wire logic                 call_en,
   input  wire elevd_pkg::slot_type  floor,
   input  wire logic [1:0]           route,
   input  wire elevd_pkg::car_type   car_a,
   input  wire elevd_pkg::car_type   car_b,
   output elevd_pkg::queue_type      q_a,
   output elevd_pkg::queue_type      q_b
);

   localparam elevd_pkg::slot_type TOP_FLOOR = 3'(FLOORS);

   typedef struct packed {
      logic                 hit;
      elevd_pkg::queue_type q;
   } try_type;

   // floor ahead of a moving car
   function automatic logic on_way(input elevd_pkg::slot_type pos,
                                   input elevd_pkg::dir_type dir,
                                   input elevd_pkg::slot_type f);
      return (f > pos && dir == elevd_pkg::DIR_UP) ||
             (f < pos && dir == elevd_pkg::DIR_DOWN);
   endfunction

   // call routed to one car only
   function automatic elevd_pkg::queue_type call_single(input elevd_pkg::car_type c,
                                                        input elevd_pkg::slot_type f);
      elevd_pkg::queue_type r;
      r = c.q;
      if (c.dir == elevd_pkg::DIR_IDLE) begin
         r[0] = f;
      end else if (c.q[1] == '0) begin
         r[1] = f;
      end else if (c.q[2] == '0) begin
         if (on_way(c.pos, c.dir, f)) begin
            r[1] = f;
         end else begin
            r[2] = f;
         end
      end
      return r;
   endfunction

   // shared attempt: on the way, or between the first two targets
   function automatic try_type call_try(input elevd_pkg::car_type c,
                                        input elevd_pkg::slot_type f);
      try_type r;
      r.hit = 1'b0;
      r.q   = c.q;
      if (c.q[1] == '0) begin
         if (on_way(c.pos, c.dir, f)) begin
            r.hit  = 1'b1;
            r.q[1] = f;
         end
      end else if (c.q[2] == '0) begin
         if ((c.q[0] < f && f < c.q[1]) || (c.q[0] > f && f > c.q[1])) begin
            r.hit  = 1'b1;
            r.q[2] = c.q[1];
            r.q[1] = f;
         end
      end
      return r;
   endfunction

   logic    dup;
   logic    valid_floor;
   try_type try_a;
   try_type try_b;

   // duplicate check across both queues
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < elevd_pkg::QUEUE_SLOTS; i++) begin
         if (car_a.q[i] == floor || car_b.q[i] == floor) begin
            dup = 1'b1;
         end
      end
   end

   assign valid_floor = (floor != '0) && (floor <= TOP_FLOOR);
   assign try_a = call_try(car_a, floor);
   assign try_b = call_try(car_b, floor);

   // routing of an accepted call
   always_comb begin
      q_a = car_a.q;
      q_b = car_b.q;
      if (call_en && valid_floor && !dup) begin
         unique case (route)
            elevd_pkg::ROUTE_A: q_a = call_single(car_a, floor);
            elevd_pkg::ROUTE_B: q_b = call_single(car_b, floor);
            elevd_pkg::ROUTE_BOTH: begin
               priority if (car_a.dir == elevd_pkg::DIR_IDLE) begin
                  q_a[0] = floor;
               end else if (car_b.dir == elevd_pkg::DIR_IDLE) begin
                  q_b[0] = floor;
               end else if (try_a.hit) begin
                  q_a = try_a.q;
               end else if (try_b.hit) begin
                  q_b = try_b.q;
               end else begin
                  if (car_a.q[2] == '0) q_a[2] = floor;
                  if (car_b.q[2] == '0) q_b[2] = floor;
               end
            end
            default: begin
               q_a = car_a.q;
               q_b = car_b.q;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ src/elevd_car.sv @@
// one car: floor sensor step, target pop, direction and display code
`default_nettype none

module elevd_car #(
   parameter int FLOORS = elevd_pkg::FLOORS_DEFAULT
) (
   input  wire logic                 sense,
   input  wire elevd_pkg::car_type   cur,
   input  wire elevd_pkg::queue_type q_call,
   output elevd_pkg::car_type        nxt,
   output elevd_pkg::car_out_type    view
);

   localparam elevd_pkg::slot_type TOP_FLOOR = 3'(FLOORS);

   elevd_pkg::slot_type  pos;
   elevd_pkg::queue_type q;
   logic                 moved;

   // advance one floor on a sensor pulse, never past the end floors
   always_comb begin
      pos   = cur.pos;
      moved = 1'b0;
      if (sense) begin
         if (cur.dir == elevd_pkg::DIR_UP && cur.pos < TOP_FLOOR) begin
            pos   = cur.pos + 3'd1;
            moved = 1'b1;
         end else if (cur.dir == elevd_pkg::DIR_DOWN && cur.pos > 3'd1) begin
            pos   = cur.pos - 3'd1;
            moved = 1'b1;
         end
      end
   end

   // pop a reached target, then pick the direction
   always_comb begin
      q = q_call;
      if (pos == q_call[0]) begin
         q[0] = q_call[1];
         q[1] = q_call[2];
         q[2] = '0;
      end
      nxt.q   = q;
      nxt.pos = pos;
      nxt.dir = cur.dir;
      priority if (q[0] == '0) begin
         nxt.dir = elevd_pkg::DIR_IDLE;
      end else if (q[0] > pos) begin
         nxt.dir = elevd_pkg::DIR_UP;
      end else if (q[0] < pos) begin
         nxt.dir = elevd_pkg::DIR_DOWN;
      end
   end

   // motor drives and display
   always_comb begin
      view.up       = (nxt.dir == elevd_pkg::DIR_UP);
      view.down     = (nxt.dir == elevd_pkg::DIR_DOWN);
      view.moved    = moved;
      view.segments = elevd_pkg::seg_code(pos);
      if (nxt.dir == elevd_pkg::DIR_IDLE) begin
         view.segments = view.segments & elevd_pkg::IDLE_MASK;
      end
   end

endmodule

`default_nettype wire

@@ src/dual_elevator_dispatch.sv @@
// Dual elevator dispatcher top level: car state, routing mode and result register.
// Response: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless a stalled response holds it; the single-pass update logic sets this figure.
// A request is taken while the response register is empty or being drained.
// Reset (synchronous, active high): queues empty, both cars at floor 1 and idle,
// routing to both cars, no response pending.
`default_nettype none

module dual_elevator_dispatch #(
   parameter int FLOORS = elevd_pkg::FLOORS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_op,
   input  wire logic [2:0] req_floor,
   input  wire logic [1:0] req_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_car_a_up,
   output logic            rsp_car_a_down,
   output logic            rsp_car_b_up,
   output logic            rsp_car_b_down,
   output logic [2:0]      rsp_floor_a,
   output logic [2:0]      rsp_floor_b,
   output logic [7:0]      rsp_segments_a,
   output logic [7:0]      rsp_segments_b,
   output logic            rsp_refresh
);

   elevd_pkg::car_type     car_a_ff, car_a_in;
   elevd_pkg::car_type     car_b_ff, car_b_in;
   logic [1:0]             route_ff, route_in;
   logic                   rsp_valid_ff;
   elevd_pkg::car_out_type view_a, view_b;
   elevd_pkg::queue_type   q_call_a, q_call_b;
   logic                   accept;
   logic                   is_call, sense_a, sense_b;
   elevd_pkg::op_type      op;

   // handshake: stall only while a response waits and is itself stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // operation decode
   always_comb begin
      op      = elevd_pkg::op_type'(req_op);
      is_call = 1'b0;
      sense_a = 1'b0;
      sense_b = 1'b0;
      route_in = route_ff;
      unique case (op)
         elevd_pkg::OP_CALL:    is_call = 1'b1;
         elevd_pkg::OP_MODE: begin
            if (req_mode != elevd_pkg::ROUTE_NONE) route_in = req_mode;
         end
         elevd_pkg::OP_SENSE_A: sense_a = 1'b1;
         elevd_pkg::OP_SENSE_B: sense_b = 1'b1;
         default: begin
            is_call = 1'b0;
         end
      endcase
   end

   // call routing
   elevd_call #(.FLOORS(FLOORS)) u_call (
      .call_en (is_call),
      .floor   (req_floor),
      .route   (route_ff),
      .car_a   (car_a_ff),
      .car_b   (car_b_ff),
      .q_a     (q_call_a),
      .q_b     (q_call_b)
   );

   // per-car update
   elevd_car #(.FLOORS(FLOORS)) u_car_a (
      .sense  (sense_a),
      .cur    (car_a_ff),
      .q_call (q_call_a),
      .nxt    (car_a_in),
      .view   (view_a)
   );

   elevd_car #(.FLOORS(FLOORS)) u_car_b (
      .sense  (sense_b),
      .cur    (car_b_ff),
      .q_call (q_call_b),
      .nxt    (car_b_in),
      .view   (view_b)
   );

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         car_a_ff     <= '{q: '0, pos: 3'd1, dir: elevd_pkg::DIR_IDLE};
         car_b_ff     <= '{q: '0, pos: 3'd1, dir: elevd_pkg::DIR_IDLE};
         route_ff     <= elevd_pkg::ROUTE_BOTH;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            car_a_ff <= car_a_in;
            car_b_ff <= car_b_in;
            route_ff <= route_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_car_a_up   <= view_a.up;
         rsp_car_a_down <= view_a.down;
         rsp_car_b_up   <= view_b.up;
         rsp_car_b_down <= view_b.down;
         rsp_floor_a    <= car_a_in.pos;
         rsp_floor_b    <= car_b_in.pos;
         rsp_segments_a <= view_a.segments;
         rsp_segments_b <= view_b.segments;
         rsp_refresh    <= view_a.moved || view_b.moved ||
                           (car_a_in.dir != car_a_ff.dir) ||
                           (car_b_in.dir != car_b_ff.dir);
      end
   end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the dual elevator dispatcher: directed rows, then random requests
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLOORS       = elevd_pkg::FLOORS_DEFAULT;
   localparam int CAR_A        = 0;
   localparam int CAR_B        = 1;
   localparam int IDLE_PERCENT = 8;
   localparam int RANDOM_ITEMS = 1350;
   localparam int STEADY_FIRST = 500;
   localparam int STEADY_LAST  = 800;
   localparam int PAUSE_AT     = 1000;
   localparam int DRAIN_CYCLES = 4;
   localparam int TIMEOUT_NS   = 200000;

   // op codes outside the package enum, they behave as a tick
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // display codes by floor number, point bit set
   localparam logic [7:0] FLOOR_GLYPH [8] = '{
      8'hFC, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8
   };

   // one response as seen on the result channel
   typedef struct packed {
      logic       a_up;
      logic       a_down;
      logic       b_up;
      logic       b_down;
      logic [2:0] floor_a;
      logic [2:0] floor_b;
      logic [7:0] seg_a;
      logic [7:0] seg_b;
      logic       refresh;
   } status_type;

   // one directed request, with a typed response where it is obvious
   typedef struct packed {
      logic [2:0]          op;
      elevd_pkg::slot_type f;
      logic [1:0]          m;
      logic                fixed;
      status_type          want;
   } stim_row_type;

   localparam status_type NO_VIEW   = '0;
   localparam status_type IDLE_VIEW = '{a_up: 1'b0, a_down: 1'b0, b_up: 1'b0, b_down: 1'b0,
                                        floor_a: 3'd1, floor_b: 3'd1, seg_a: 8'h79,
                                        seg_b: 8'h79, refresh: 1'b0};
   localparam status_type A_UP_VIEW = '{a_up: 1'b1, a_down: 1'b0, b_up: 1'b0, b_down: 1'b0,
                                        floor_a: 3'd1, floor_b: 3'd1, seg_a: 8'hF9,
                                        seg_b: 8'h79, refresh: 1'b1};

   localparam stim_row_type DIRECTED [25] = '{
      // state straight after reset, ignored requests leave it alone
      '{elevd_pkg::OP_TICK,    3'd0, 2'd0,                  1'b1, IDLE_VIEW},
      '{OP_SPARE_LAST,         3'd7, 2'd3,                  1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_CALL,    3'd0, 2'd0,                  1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_CALL,    3'd7, 2'd3,                  1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_CALL,    3'd5, 2'd0,                  1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_MODE,    3'd7, elevd_pkg::ROUTE_NONE, 1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_SENSE_A, 3'd4, 2'd3,                  1'b1, IDLE_VIEW},
      '{elevd_pkg::OP_SENSE_B, 3'd4, 2'd3,                  1'b1, IDLE_VIEW},
      // first call goes to the idle car A, top floor
      '{elevd_pkg::OP_CALL,    3'd4, 2'd0,                  1'b1, A_UP_VIEW},
      // duplicate, idle car B, on the way, both third slots
      '{elevd_pkg::OP_CALL,    3'd4, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd3, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd2, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd1, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd3, 2'd0,                  1'b0, NO_VIEW},
      // run the cars to their targets
      '{elevd_pkg::OP_SENSE_A, 3'd0, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_SENSE_A, 3'd0, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_SENSE_A, 3'd0, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_SENSE_B, 3'd0, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_SENSE_B, 3'd0, 2'd0,                  1'b0, NO_VIEW},
      // single-car routing
      '{elevd_pkg::OP_MODE,    3'd0, elevd_pkg::ROUTE_A,    1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd4, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd1, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_MODE,    3'd0, elevd_pkg::ROUTE_B,    1'b0, NO_VIEW},
      '{elevd_pkg::OP_CALL,    3'd2, 2'd0,                  1'b0, NO_VIEW},
      '{elevd_pkg::OP_MODE,    3'd0, elevd_pkg::ROUTE_BOTH, 1'b0, NO_VIEW}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = '0;
   logic [2:0] req_floor = '0;
   logic [1:0] req_mode = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_car_a_up;
   logic       rsp_car_a_down;
   logic       rsp_car_b_up;
   logic       rsp_car_b_down;
   logic [2:0] rsp_floor_a;
   logic [2:0] rsp_floor_b;
   logic [7:0] rsp_segments_a;
   logic [7:0] rsp_segments_b;
   logic       rsp_refresh;

   // side information that travels with the request being offered
   logic       row_fixed = 1'b0;
   status_type row_want = '0;
   bit         steady_run = 1'b0;

   // predicted car state
   elevd_pkg::slot_type car_q [2][elevd_pkg::QUEUE_SLOTS];
   elevd_pkg::slot_type car_pos [2];
   elevd_pkg::dir_type  car_dir [2];
   logic [1:0]          route_mode;

   status_type pending_status [$];
   int         errors = 0;
   int         n_checked = 0;
   int         n_requests = 0;
   int         n_calls = 0;
   int         n_modes = 0;
   int         n_sensors = 0;
   int         n_moves = 0;

   dual_elevator_dispatch #(.FLOORS(FLOORS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_floor      (req_floor),
      .req_mode       (req_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_car_a_up   (rsp_car_a_up),
      .rsp_car_a_down (rsp_car_a_down),
      .rsp_car_b_up   (rsp_car_b_up),
      .rsp_car_b_down (rsp_car_b_down),
      .rsp_floor_a    (rsp_floor_a),
      .rsp_floor_b    (rsp_floor_b),
      .rsp_segments_a (rsp_segments_a),
      .rsp_segments_b (rsp_segments_b),
      .rsp_refresh    (rsp_refresh)
   );

   always #1 clock = ~clock;

   // predictor: reset state
   function automatic void clear_cars();
      for (int c = 0; c < 2; c++) begin
         for (int s = 0; s < elevd_pkg::QUEUE_SLOTS; s++) car_q[c][s] = '0;
         car_pos[c] = 3'd1;
         car_dir[c] = elevd_pkg::DIR_IDLE;
      end
      route_mode = elevd_pkg::ROUTE_BOTH;
   endfunction

   // a floor ahead of a moving car goes into slot 1
   function automatic bit park_on_way(int c, elevd_pkg::slot_type f);
      if ((f > car_pos[c] && car_dir[c] == elevd_pkg::DIR_UP) ||
          (f < car_pos[c] && car_dir[c] == elevd_pkg::DIR_DOWN)) begin
         car_q[c][1] = f;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // call routed to one car only
   function automatic void route_single(int c, elevd_pkg::slot_type f);
      if (car_dir[c] == elevd_pkg::DIR_IDLE) begin
         car_q[c][0] = f;
      end else if (car_q[c][1] == '0) begin
         car_q[c][1] = f;
      end else if (car_q[c][2] == '0) begin
         if (!park_on_way(c, f)) car_q[c][2] = f;
      end
   endfunction

   // shared routing: on the way, or between the current and next target
   function automatic bit try_shared(int c, elevd_pkg::slot_type f);
      if (car_q[c][1] == '0) return park_on_way(c, f);
      if (car_q[c][2] == '0 &&
          ((car_q[c][0] < f && f < car_q[c][1]) || (car_q[c][0] > f && f > car_q[c][1]))) begin
         car_q[c][2] = car_q[c][1];
         car_q[c][1] = f;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // floor call: drop bad floors and duplicates, then route
   function automatic void take_call(elevd_pkg::slot_type f);
      if (f == '0 || f > FLOORS) return;
      for (int s = 0; s < elevd_pkg::QUEUE_SLOTS; s++)
         if (car_q[CAR_A][s] == f || car_q[CAR_B][s] == f) return;
      case (route_mode)
         elevd_pkg::ROUTE_A: route_single(CAR_A, f);
         elevd_pkg::ROUTE_B: route_single(CAR_B, f);
         elevd_pkg::ROUTE_BOTH: begin
            if (car_dir[CAR_A] == elevd_pkg::DIR_IDLE) begin
               car_q[CAR_A][0] = f;
            end else if (car_dir[CAR_B] == elevd_pkg::DIR_IDLE) begin
               car_q[CAR_B][0] = f;
            end else if (!try_shared(CAR_A, f)) begin
               if (!try_shared(CAR_B, f)) begin
                  if (car_q[CAR_A][2] == '0) car_q[CAR_A][2] = f;
                  if (car_q[CAR_B][2] == '0) car_q[CAR_B][2] = f;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // floor sensor pulse, never past the end floors
   function automatic bit advance_car(int c);
      if (car_dir[c] == elevd_pkg::DIR_UP && car_pos[c] < FLOORS) begin
         car_pos[c] = car_pos[c] + 3'd1;
         return 1'b1;
      end
      if (car_dir[c] == elevd_pkg::DIR_DOWN && car_pos[c] > 3'd1) begin
         car_pos[c] = car_pos[c] - 3'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // pop a reached target, then pick the direction
   function automatic void settle_car(int c);
      if (car_pos[c] == car_q[c][0]) begin
         car_q[c][0] = car_q[c][1];
         car_q[c][1] = car_q[c][2];
         car_q[c][2] = '0;
      end
      if (car_q[c][0] == '0)
         car_dir[c] = elevd_pkg::DIR_IDLE;
      else if (car_q[c][0] > car_pos[c])
         car_dir[c] = elevd_pkg::DIR_UP;
      else if (car_q[c][0] < car_pos[c])
         car_dir[c] = elevd_pkg::DIR_DOWN;
   endfunction

   function automatic logic [7:0] car_glyph(int c);
      return FLOOR_GLYPH[car_pos[c]] &
             ((car_dir[c] == elevd_pkg::DIR_IDLE) ? elevd_pkg::IDLE_MASK : 8'hFF);
   endfunction

   // predictor: apply one request and form its response
   function automatic status_type dispatch_event(logic [2:0] op, elevd_pkg::slot_type f,
                                                 logic [1:0] m);
      elevd_pkg::dir_type was_a;
      elevd_pkg::dir_type was_b;
      bit                 moved;
      status_type         s;
      was_a = car_dir[CAR_A];
      was_b = car_dir[CAR_B];
      moved = 1'b0;
      case (op)
         elevd_pkg::OP_CALL:    take_call(f);
         elevd_pkg::OP_MODE:    if (m != elevd_pkg::ROUTE_NONE) route_mode = m;
         elevd_pkg::OP_SENSE_A: moved = advance_car(CAR_A);
         elevd_pkg::OP_SENSE_B: moved = advance_car(CAR_B);
         default: ;
      endcase
      settle_car(CAR_A);
      settle_car(CAR_B);
      if (moved) n_moves++;
      s.a_up    = (car_dir[CAR_A] == elevd_pkg::DIR_UP);
      s.a_down  = (car_dir[CAR_A] == elevd_pkg::DIR_DOWN);
      s.b_up    = (car_dir[CAR_B] == elevd_pkg::DIR_UP);
      s.b_down  = (car_dir[CAR_B] == elevd_pkg::DIR_DOWN);
      s.floor_a = car_pos[CAR_A];
      s.floor_b = car_pos[CAR_B];
      s.seg_a   = car_glyph(CAR_A);
      s.seg_b   = car_glyph(CAR_B);
      s.refresh = moved || car_dir[CAR_A] != was_a || car_dir[CAR_B] != was_b;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // result checking and prediction, both on the rising edge
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         clear_cars();
         pending_status.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.a_up    = rsp_car_a_up;
            got.a_down  = rsp_car_a_down;
            got.b_up    = rsp_car_b_up;
            got.b_down  = rsp_car_b_down;
            got.floor_a = rsp_floor_a;
            got.floor_b = rsp_floor_b;
            got.seg_a   = rsp_segments_a;
            got.seg_b   = rsp_segments_b;
            got.refresh = rsp_refresh;
            if (pending_status.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_status.pop_front();
               n_checked++;
               check_field("car_a_up", 8'(got.a_up), 8'(want.a_up));
               check_field("car_a_down", 8'(got.a_down), 8'(want.a_down));
               check_field("car_b_up", 8'(got.b_up), 8'(want.b_up));
               check_field("car_b_down", 8'(got.b_down), 8'(want.b_down));
               check_field("floor_a", 8'(got.floor_a), 8'(want.floor_a));
               check_field("floor_b", 8'(got.floor_b), 8'(want.floor_b));
               check_field("segments_a", got.seg_a, want.seg_a);
               check_field("segments_b", got.seg_b, want.seg_b);
               check_field("refresh", 8'(got.refresh), 8'(want.refresh));
            end
         end
         if (req_valid && !req_stall) begin
            want = dispatch_event(req_op, req_floor, req_mode);
            if (row_fixed) want = row_want;
            pending_status.push_back(want);
            n_requests++;
            if (req_op == elevd_pkg::OP_CALL) n_calls++;
            if (req_op == elevd_pkg::OP_MODE) n_modes++;
            if (req_op == elevd_pkg::OP_SENSE_A || req_op == elevd_pkg::OP_SENSE_B)
               n_sensors++;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(99) < IDLE_PERCENT);
   end

   // offer one request, with random gaps, and hold it until taken
   task automatic send_request(input logic [2:0] op, input elevd_pkg::slot_type f,
                               input logic [1:0] m, input logic fixed,
                               input status_type want);
      @(negedge clock);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_op    <= op;
      req_floor <= f;
      req_mode  <= m;
      row_fixed <= fixed;
      row_want  <= want;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and let every outstanding response come back
   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int                  pick;
      logic [2:0]          op;
      elevd_pkg::slot_type f;
      logic [1:0]          m;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_request(DIRECTED[i].op, DIRECTED[i].f, DIRECTED[i].m, DIRECTED[i].fixed,
                      DIRECTED[i].want);

      // random traffic, mostly valid calls and sensor pulses
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady_run = (i >= STEADY_FIRST && i < STEADY_LAST);
         pick = $urandom_range(99);
         f = 3'($urandom_range(7, 0));
         m = 2'($urandom_range(3, 0));
         if (pick < 30) begin
            op = elevd_pkg::OP_CALL;
            f  = 3'($urandom_range(FLOORS, 1));
         end else if (pick < 38) begin
            op = elevd_pkg::OP_CALL;
         end else if (pick < 63) begin
            op = elevd_pkg::OP_SENSE_A;
         end else if (pick < 88) begin
            op = elevd_pkg::OP_SENSE_B;
         end else if (pick < 94) begin
            op = elevd_pkg::OP_MODE;
         end else if (pick < 97) begin
            op = elevd_pkg::OP_TICK;
         end else begin
            op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
         end
         send_request(op, f, m, 1'b0, NO_VIEW);
         if (i == PAUSE_AT) wait_for_quiet();
      end
      steady_run = 1'b0;

      // drain
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_status.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_status.size()));

      $display("covered %0d requests: %0d calls, %0d mode selects, %0d sensor pulses (%0d moves)",
               n_requests, n_calls, n_modes, n_sensors, n_moves);
      $display("checked %0d responses field by field, %0d mismatches", n_checked, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("timed out with %0d responses outstanding", pending_status.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
